// File: rtl/pmfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged monochrome frame buffer package
// Shared transaction types, operation and command codes, default sizes.
// ----------------------------------------------------------------------------
package pmfb_pkg;

  localparam int NUM_PARTS_DEF   = 2;
  localparam int NUM_PAGES_DEF   = 8;
  localparam int NUM_COLUMNS_DEF = 128;
  localparam int ROWS_PER_PAGE   = 8;
  localparam int QUEUE_DEPTH     = 2;

  typedef logic [2:0] op_t;

  localparam op_t OP_RD_BYTE = 3'd0;
  localparam op_t OP_WR_BYTE = 3'd1;
  localparam op_t OP_WR_PIX  = 3'd2;
  localparam op_t OP_GET_PIX = 3'd3;
  localparam op_t OP_FILL    = 3'd4;
  localparam op_t OP_COPY    = 3'd5;
  localparam op_t OP_OR      = 3'd6;
  localparam op_t OP_ANDN    = 3'd7;

  typedef logic [3:0] kind_t;

  localparam kind_t K_NONE    = 4'd0;
  localparam kind_t K_RD_BYTE = 4'd1;
  localparam kind_t K_WR_BYTE = 4'd2;
  localparam kind_t K_WR_PIX  = 4'd3;
  localparam kind_t K_GET_PIX = 4'd4;
  localparam kind_t K_FILL    = 4'd5;
  localparam kind_t K_COPY    = 4'd6;
  localparam kind_t K_OR      = 4'd7;
  localparam kind_t K_ANDN    = 4'd8;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] column;
    logic [6:0] row;
    logic [2:0] page;
    logic [7:0] data;
    logic       dest_part;
    logic       src_part;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       out_of_range;
  } out_t;

  typedef struct packed {
    kind_t      kind;
    logic       oor;
    logic       part;
    logic       src_part;
    logic [3:0] page;
    logic [7:0] column;
    logic [2:0] bit_idx;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/paged_monochrome_frame_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged monochrome frame buffer
// Two-part page-packed monochrome store with byte, pixel and whole-part
// operations behind a command port and a one-cycle result strobe.
// ----------------------------------------------------------------------------
// After reset the block clears its store: busy stays high while it writes zero
// to all 2**AW bytes, where AW = 1 + clog2(NUM_PAGES) + clog2(NUM_COLUMNS).
// Every accepted transaction gives exactly one result on out_valid, which the
// receiver must take in that cycle. Transactions go through a two-entry queue
// into a back end that owns the single store. In the back end, a write byte or
// a rejected transaction is answered straight from idle, read byte, get pixel
// and write pixel pass through an access state because of the registered
// store read, and fill, copy, OR and and-not sweep one part at one byte per
// cycle. Busy rises when the queue is full.
module paged_monochrome_frame_buffer #(
  parameter int NUM_PARTS   = pmfb_pkg::NUM_PARTS_DEF,
  parameter int NUM_PAGES   = pmfb_pkg::NUM_PAGES_DEF,
  parameter int NUM_COLUMNS = pmfb_pkg::NUM_COLUMNS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pmfb_pkg::in_t  in_data,
  output logic           out_valid,
  output pmfb_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);

  logic                push;
  pmfb_pkg::cmd_t      push_cmd;
  pmfb_pkg::cmd_t      head;
  pmfb_pkg::q_status_t q_status;
  logic                pop;
  logic                clearing;

  assign busy = clearing || q_status.full;

  pmfb_front #(
    .NUM_PARTS   (NUM_PARTS),
    .NUM_PAGES   (NUM_PAGES),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  pmfb_queue #(
    .DEPTH (pmfb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  pmfb_back #(
    .NUM_PAGES   (NUM_PAGES),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_status.empty),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("Store clearing pass did not start after reset.");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("Transaction pushed into a full queue.");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty && !clearing)
    else $error("Back end took a command from an empty queue or while clearing.");

  a_oor_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |-> out_data.read_data == '0)
    else $error("Out-of-range result carries nonzero data.");

endmodule

// File: rtl/pmfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged monochrome frame buffer front end
// Holds the selected part register and turns each accepted transaction into
// a classified command with its bounds and part checks already resolved.
// ----------------------------------------------------------------------------
module pmfb_front #(
  parameter int NUM_PARTS   = pmfb_pkg::NUM_PARTS_DEF,
  parameter int NUM_PAGES   = pmfb_pkg::NUM_PAGES_DEF,
  parameter int NUM_COLUMNS = pmfb_pkg::NUM_COLUMNS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  pmfb_pkg::in_t  in_data,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  output logic           push,
  output pmfb_pkg::cmd_t push_cmd
);

  logic sel_part_r;
  logic sel_part_nxt;
  logic col_oor;
  logic page_oor;
  logic row_oor;
  logic sel_ok;
  logic dest_ok;
  logic src_ok;

  always_comb begin
    sel_part_nxt = cfg_we ? cfg_wdata : sel_part_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_part_r <= 1'b0;
    end else begin
      sel_part_r <= sel_part_nxt;
    end
  end

  assign push     = start && !busy;
  assign col_oor  = {1'b0, in_data.column} >= 9'(NUM_COLUMNS);
  assign page_oor = {2'b0, in_data.page} >= 5'(NUM_PAGES);
  assign row_oor  = {1'b0, in_data.row} >= 8'(NUM_PAGES * pmfb_pkg::ROWS_PER_PAGE);
  assign sel_ok   = {3'b0, sel_part_r} < 4'(NUM_PARTS);
  assign dest_ok  = {3'b0, in_data.dest_part} < 4'(NUM_PARTS);
  assign src_ok   = {3'b0, in_data.src_part} < 4'(NUM_PARTS);

  always_comb begin
    push_cmd          = '0;
    push_cmd.kind     = pmfb_pkg::K_NONE;
    push_cmd.data     = in_data.data;
    push_cmd.column   = in_data.column;
    push_cmd.src_part = in_data.src_part;
    case (in_data.op)
      pmfb_pkg::OP_RD_BYTE, pmfb_pkg::OP_WR_BYTE: begin
        push_cmd.part = sel_part_r;
        push_cmd.page = {1'b0, in_data.page};
        if (col_oor || page_oor) begin
          push_cmd.oor = 1'b1;
        end else if (sel_ok) begin
          push_cmd.kind = (in_data.op == pmfb_pkg::OP_RD_BYTE) ? pmfb_pkg::K_RD_BYTE
                                                                : pmfb_pkg::K_WR_BYTE;
        end
      end
      pmfb_pkg::OP_WR_PIX, pmfb_pkg::OP_GET_PIX: begin
        push_cmd.part    = sel_part_r;
        push_cmd.page    = in_data.row[6:3];
        push_cmd.bit_idx = in_data.row[2:0];
        if (col_oor || row_oor) begin
          push_cmd.oor = 1'b1;
        end else if (sel_ok) begin
          push_cmd.kind = (in_data.op == pmfb_pkg::OP_WR_PIX) ? pmfb_pkg::K_WR_PIX
                                                               : pmfb_pkg::K_GET_PIX;
        end
      end
      pmfb_pkg::OP_FILL: begin
        push_cmd.part = in_data.dest_part;
        if (dest_ok) begin
          push_cmd.kind = pmfb_pkg::K_FILL;
        end
      end
      pmfb_pkg::OP_COPY: begin
        push_cmd.part = in_data.dest_part;
        if (dest_ok && src_ok) begin
          push_cmd.kind = pmfb_pkg::K_COPY;
        end
      end
      pmfb_pkg::OP_OR: begin
        push_cmd.part = in_data.dest_part;
        if (dest_ok && src_ok) begin
          push_cmd.kind = pmfb_pkg::K_OR;
        end
      end
      pmfb_pkg::OP_ANDN: begin
        push_cmd.part = in_data.dest_part;
        if (dest_ok && src_ok) begin
          push_cmd.kind = pmfb_pkg::K_ANDN;
        end
      end
      default: begin
        push_cmd.kind = pmfb_pkg::K_NONE;
      end
    endcase
  end

endmodule

// File: rtl/pmfb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged monochrome frame buffer command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pmfb_queue #(
  parameter int DEPTH = pmfb_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pmfb_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output pmfb_pkg::cmd_t      head,
  output pmfb_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pmfb_pkg::cmd_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW-1:0]  rd_ptr_nxt;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           do_push;
  logic           do_pop;

  assign status.full  = count_r == CW'(DEPTH);
  assign status.empty = count_r == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/pmfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged monochrome frame buffer back end
// Owns the byte store, runs the clearing pass after reset, executes byte and
// pixel commands and sweeps whole parts for fill, copy, OR and and-not.
// ----------------------------------------------------------------------------
module pmfb_back #(
  parameter int NUM_PAGES   = pmfb_pkg::NUM_PAGES_DEF,
  parameter int NUM_COLUMNS = pmfb_pkg::NUM_COLUMNS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pmfb_pkg::cmd_t head,
  input  logic           q_empty,
  output logic           pop,
  output logic           clearing,
  output logic           out_valid,
  output pmfb_pkg::out_t out_data
);

  localparam int PGW   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW    = $clog2(NUM_COLUMNS);
  localparam int OFF_W = PGW + CW;
  localparam int AW    = OFF_W + 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ACC   = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  logic [7:0]       mem [2**AW];
  logic [7:0]       rda_q;
  logic [7:0]       rdb_q;
  logic             we;
  logic [AW-1:0]    wa;
  logic [7:0]       wd;
  logic [AW-1:0]    ra_a;
  logic [AW-1:0]    ra_b;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  pmfb_pkg::cmd_t   cmd_r;
  pmfb_pkg::cmd_t   cmd_nxt;
  logic [AW-1:0]    clr_r;
  logic [AW-1:0]    clr_nxt;
  logic [OFF_W:0]   cnt_r;
  logic [OFF_W:0]   cnt_nxt;
  logic             pend_r;
  logic             pend_nxt;
  logic [OFF_W-1:0] pend_off_r;
  logic [OFF_W-1:0] pend_off_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  pmfb_pkg::out_t   out_r;
  pmfb_pkg::out_t   out_nxt;
  logic [7:0]       mask;
  logic [AW-1:0]    head_addr;
  logic [AW-1:0]    cmd_addr;
  logic             issue;

  assign head_addr = {head.part, head.page[PGW-1:0], head.column[CW-1:0]};
  assign cmd_addr  = {cmd_r.part, cmd_r.page[PGW-1:0], cmd_r.column[CW-1:0]};
  assign mask      = 8'b1 << cmd_r.bit_idx;
  assign issue     = !cnt_r[OFF_W];
  assign clearing  = state_r == ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_off_nxt  = pend_off_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    pop           = 1'b0;
    we            = 1'b0;
    wa            = cmd_addr;
    wd            = cmd_r.data;
    ra_a          = head_addr;
    ra_b          = head_addr;
    case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        wa      = clr_r;
        wd      = '0;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          case (head.kind)
            pmfb_pkg::K_RD_BYTE, pmfb_pkg::K_WR_PIX, pmfb_pkg::K_GET_PIX: begin
              state_nxt = ST_ACC;
            end
            pmfb_pkg::K_WR_BYTE: begin
              we            = 1'b1;
              wa            = head_addr;
              wd            = head.data;
              out_valid_nxt = 1'b1;
            end
            pmfb_pkg::K_FILL, pmfb_pkg::K_COPY, pmfb_pkg::K_OR, pmfb_pkg::K_ANDN: begin
              state_nxt = ST_SWEEP;
              cnt_nxt   = '0;
              pend_nxt  = 1'b0;
            end
            default: begin
              out_valid_nxt        = 1'b1;
              out_nxt.out_of_range = head.oor;
            end
          endcase
        end
      end
      ST_ACC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        case (cmd_r.kind)
          pmfb_pkg::K_RD_BYTE: begin
            out_nxt.read_data = rda_q;
          end
          pmfb_pkg::K_GET_PIX: begin
            out_nxt.read_data = {7'b0, rda_q[cmd_r.bit_idx]};
          end
          default: begin
            we = 1'b1;
            wd = (cmd_r.data != '0) ? (rda_q | mask) : (rda_q & ~mask);
          end
        endcase
      end
      default: begin
        ra_a = {cmd_r.src_part, cnt_r[OFF_W-1:0]};
        ra_b = {cmd_r.part, cnt_r[OFF_W-1:0]};
        pend_nxt = issue;
        if (issue) begin
          cnt_nxt      = cnt_r + 1'b1;
          pend_off_nxt = cnt_r[OFF_W-1:0];
        end
        if (pend_r) begin
          we = 1'b1;
          wa = {cmd_r.part, pend_off_r};
          case (cmd_r.kind)
            pmfb_pkg::K_FILL: wd = cmd_r.data;
            pmfb_pkg::K_COPY: wd = rda_q;
            pmfb_pkg::K_OR:   wd = rdb_q | rda_q;
            default:          wd = rdb_q & ~rda_q;
          endcase
        end
        if (!issue && !pend_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pend_off_r <= pend_off_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_q <= mem[ra_a];
    rdb_q <= mem[ra_b];
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged monochrome frame buffer testbench
// Drives byte, pixel and whole-part transactions through the command port,
// keeps its own image of both buffer parts, and checks every result strobe
// against the predicted read data and out-of-range flag. A directed table
// comes first, then random phases under both part selections and several
// sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    pmfb_pkg::in_t  cmd;
    bit             known;
    pmfb_pkg::out_t want;
  } vector_t;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  pmfb_pkg::in_t  in_data;
  logic           out_valid;
  pmfb_pkg::out_t out_data;
  logic           cfg_we;
  logic           cfg_wdata;

  logic [7:0] fb_image [pmfb_pkg::NUM_PARTS_DEF][pmfb_pkg::NUM_PAGES_DEF]
                       [pmfb_pkg::NUM_COLUMNS_DEF];
  logic           sel_part;
  pmfb_pkg::out_t expected_readback [$];
  int             mismatch_count;
  int             idle_pct;

  paged_monochrome_frame_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic pmfb_pkg::in_t cmd_of(pmfb_pkg::op_t op, int column, int row, int page,
                                           int data, int dest, int src);
    pmfb_pkg::in_t c;
    c.op        = op;
    c.column    = 8'(column);
    c.row       = 7'(row);
    c.page      = 3'(page);
    c.data      = 8'(data);
    c.dest_part = 1'(dest);
    c.src_part  = 1'(src);
    return c;
  endfunction

  function automatic pmfb_pkg::out_t apply_draw_command(pmfb_pkg::in_t c);
    pmfb_pkg::out_t r;
    int             p;
    int             x;
    r = '0;
    case (c.op)
      pmfb_pkg::OP_RD_BYTE, pmfb_pkg::OP_WR_BYTE: begin
        if (c.column >= pmfb_pkg::NUM_COLUMNS_DEF || c.page >= pmfb_pkg::NUM_PAGES_DEF) begin
          r.out_of_range = 1'b1;
        end else if (c.op == pmfb_pkg::OP_RD_BYTE) begin
          r.read_data = fb_image[sel_part][c.page][c.column];
        end else begin
          fb_image[sel_part][c.page][c.column] = c.data;
        end
      end
      pmfb_pkg::OP_WR_PIX, pmfb_pkg::OP_GET_PIX: begin
        if (c.column >= pmfb_pkg::NUM_COLUMNS_DEF ||
            c.row >= pmfb_pkg::NUM_PAGES_DEF * pmfb_pkg::ROWS_PER_PAGE) begin
          r.out_of_range = 1'b1;
        end else if (c.op == pmfb_pkg::OP_GET_PIX) begin
          r.read_data[0] = fb_image[sel_part][c.row[5:3]][c.column][c.row[2:0]];
        end else begin
          fb_image[sel_part][c.row[5:3]][c.column][c.row[2:0]] = (c.data != 8'd0);
        end
      end
      default: begin
        for (p = 0; p < pmfb_pkg::NUM_PAGES_DEF; p++) begin
          for (x = 0; x < pmfb_pkg::NUM_COLUMNS_DEF; x++) begin
            case (c.op)
              pmfb_pkg::OP_FILL: fb_image[c.dest_part][p][x] = c.data;
              pmfb_pkg::OP_COPY: fb_image[c.dest_part][p][x] = fb_image[c.src_part][p][x];
              pmfb_pkg::OP_OR: fb_image[c.dest_part][p][x] =
                  fb_image[c.dest_part][p][x] | fb_image[c.src_part][p][x];
              default: fb_image[c.dest_part][p][x] =
                  fb_image[c.dest_part][p][x] & ~fb_image[c.src_part][p][x];
            endcase
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic pmfb_pkg::in_t random_command();
    pmfb_pkg::in_t c;
    int            pick;
    c.op        = 3'($urandom_range(7));
    c.column    = 8'($urandom_range(255));
    c.row       = 7'($urandom_range(127));
    c.page      = 3'($urandom_range(7));
    c.data      = 8'($urandom_range(255));
    c.dest_part = 1'($urandom_range(1));
    c.src_part  = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 4) begin
      c.op = 3'($urandom_range(pmfb_pkg::OP_FILL, pmfb_pkg::OP_ANDN));
    end else begin
      c.op = 3'($urandom_range(pmfb_pkg::OP_RD_BYTE, pmfb_pkg::OP_GET_PIX));
      if (pick < 40) begin
        c.column = 8'($urandom_range(7));
        c.row    = 7'($urandom_range(15));
        c.page   = 3'($urandom_range(1));
      end else if (pick < 85) begin
        c.column = 8'($urandom_range(pmfb_pkg::NUM_COLUMNS_DEF - 1));
        c.row    = 7'($urandom_range(pmfb_pkg::NUM_PAGES_DEF * pmfb_pkg::ROWS_PER_PAGE - 1));
      end
    end
    return c;
  endfunction

  task automatic issue(input pmfb_pkg::in_t cmd, input bit known, input pmfb_pkg::out_t want);
    pmfb_pkg::out_t predicted;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    predicted = apply_draw_command(cmd);
    expected_readback.push_back(known ? want : predicted);
  endtask

  task automatic drain_readback();
    @(negedge clk);
    start <= 1'b0;
    while (expected_readback.size() != 0) @(posedge clk);
  endtask

  task automatic set_selected_part(input logic value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sel_part = value;
  endtask

  always @(posedge clk) begin : check_results
    pmfb_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (expected_readback.size() == 0) begin
        $error("result with no transaction pending: read_data %0h out_of_range %0b",
               out_data.read_data, out_data.out_of_range);
        mismatch_count++;
      end else begin
        want = expected_readback.pop_front();
        if (out_data.read_data !== want.read_data) begin
          $error("read_data mismatch: expected %0h, got %0h",
                 want.read_data, out_data.read_data);
          mismatch_count++;
        end
        if (out_data.out_of_range !== want.out_of_range) begin
          $error("out_of_range mismatch: expected %0b, got %0b",
                 want.out_of_range, out_data.out_of_range);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    vector_t vectors [$];
    int      idle_plan [6];
    int      p;
    int      x;
    int      ph;
    int      n;

    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    sel_part       = 1'b0;
    mismatch_count = 0;
    idle_pct       = 0;
    for (p = 0; p < pmfb_pkg::NUM_PARTS_DEF; p++) begin
      for (ph = 0; ph < pmfb_pkg::NUM_PAGES_DEF; ph++) begin
        for (x = 0; x < pmfb_pkg::NUM_COLUMNS_DEF; x++) fb_image[p][ph][x] = 8'h00;
      end
    end

    vectors.push_back('{cmd_of(pmfb_pkg::OP_RD_BYTE, 0, 0, 0, 0, 0, 0), 1'b1, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_RD_BYTE, 127, 0, 7, 0, 0, 0), 1'b1,
                        '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_RD_BYTE, 128, 0, 0, 0, 0, 0), 1'b1,
                        '{8'h00, 1'b1}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_RD_BYTE, 255, 127, 7, 255, 1, 1), 1'b1,
                        '{8'h00, 1'b1}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_WR_BYTE, 0, 0, 0, 255, 0, 0), 1'b1,
                        '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_WR_BYTE, 127, 0, 7, 'hA5, 0, 0), 1'b1,
                        '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_WR_BYTE, 200, 0, 7, 'h5A, 0, 0), 1'b1,
                        '{8'h00, 1'b1}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_RD_BYTE, 127, 0, 7, 0, 0, 0), 1'b0,
                        '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_WR_PIX, 5, 63, 0, 1, 0, 0), 1'b1, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_WR_PIX, 5, 64, 0, 1, 0, 0), 1'b1, '{8'h00, 1'b1}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_WR_PIX, 128, 0, 0, 255, 0, 0), 1'b1,
                        '{8'h00, 1'b1}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_GET_PIX, 5, 63, 0, 0, 0, 0), 1'b0,
                        '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_GET_PIX, 255, 127, 0, 0, 0, 0), 1'b1,
                        '{8'h00, 1'b1}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_WR_PIX, 0, 3, 0, 0, 0, 0), 1'b1, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_RD_BYTE, 0, 0, 0, 0, 0, 0), 1'b0, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_FILL, 0, 0, 0, 'h3C, 1, 0), 1'b1, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_OR, 0, 0, 0, 0, 1, 0), 1'b1, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_ANDN, 0, 0, 0, 0, 0, 1), 1'b1, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_RD_BYTE, 127, 0, 7, 0, 0, 0), 1'b0,
                        '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_COPY, 0, 0, 0, 0, 1, 0), 1'b1, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_COPY, 0, 0, 0, 0, 0, 0), 1'b1, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_OR, 0, 0, 0, 0, 1, 1), 1'b1, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_ANDN, 0, 0, 0, 0, 0, 0), 1'b1, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_RD_BYTE, 0, 0, 0, 0, 0, 0), 1'b0, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_FILL, 0, 0, 0, 255, 0, 1), 1'b1, '{8'h00, 1'b0}});
    vectors.push_back('{cmd_of(pmfb_pkg::OP_GET_PIX, 127, 0, 0, 0, 0, 0), 1'b0,
                        '{8'h00, 1'b0}});

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    set_selected_part(1'b0);

    for (n = 0; n < vectors.size(); n++) begin
      issue(vectors[n].cmd, vectors[n].known, vectors[n].want);
    end
    drain_readback();

    idle_plan = '{15, 15, 68, 68, 0, 0};
    for (ph = 0; ph < 6; ph++) begin
      set_selected_part(ph % 2 == 0);
      idle_pct = idle_plan[ph];
      for (n = 0; n < 130; n++) begin
        issue(random_command(), 1'b0, '0);
        if ($urandom_range(99) == 0) drain_readback();
      end
      drain_readback();
    end

    repeat (2100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: paged_monochrome_frame_buffer.f
rtl/pmfb_pkg.sv
rtl/pmfb_front.sv
rtl/pmfb_queue.sv
rtl/pmfb_back.sv
rtl/paged_monochrome_frame_buffer.sv
test/tb_top.sv
